// ----- design/assert_macros.svh -----
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, clocked on clk, off while arst_n is low
`define CHT_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, clocked on clk, off while arst_n is low
`define CHT_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- design/cht_pkg.sv -----
// types and constants of the chained hash table engine
// no dependencies
package cht_pkg;

	typedef enum logic [1:0] {
		KIND_LOOKUP = 2'd0,
		KIND_SET    = 2'd1,
		KIND_GOC    = 2'd2,
		KIND_REMOVE = 2'd3
	} kind_t;

	localparam logic [63:0] FMIX_C1 = 64'hff51afd7ed558ccd;
	localparam logic [63:0] FMIX_C2 = 64'hc4ceb9fe1a85ec53;
	localparam int unsigned FMIX_SHIFT = 33;
	localparam int unsigned MOD_BITS_PER_CYCLE = 4;

	typedef struct packed {
		logic load;
		logic rd_head;
		logic hit_head;
		logic walk_first;
		logic hit_pool;
		logic walk_next;
		logic wr_value;
		logic ins_head;
		logic full;
		logic rd_free;
		logic ins_pool;
		logic rm_head_last;
		logic rd_next;
		logic rm_head_pull;
		logic rm_chain;
	} cmd_t;

	typedef struct packed {
		logic  hash_done;
		kind_t kind;
		logic  head_valid;
		logic  head_hit;
		logic  head_link_null;
		logic  pool_hit;
		logic  pool_link_null;
		logic  found;
		logic  at_head;
		logic  free_empty;
	} sts_t;

endpackage

// ----- design/chained_hash_table_engine_top.sv -----
// Chained hash table engine. An item is taken when start is high and busy is low; its
// result appears for one cycle with done and cannot be held off. The hash unit runs first:
// two 64-bit multiplies as three 32x32 partial products each, then a remainder loop of
// four bits per cycle. Then the head is checked and chained cells are walked one by one,
// up to the hit or the last cell of the chain; an overflow pool insert or a head removal
// that pulls up a chained cell also passes S_POP or S_RMH. busy falls the cycle after
// done. Write bucket_count only while busy is low; a new count may strand stored entries.
// depends on cht_pkg, cht_ctrl, cht_dp
module chained_hash_table_engine_top #(
	parameter int NUM_BUCKETS  = 256,
	parameter int POOL_ENTRIES = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  kind,
	input  logic [63:0] key,
	input  logic [63:0] new_value,
	input  logic        bucket_count_we,
	input  logic [8:0]  bucket_count,
	output logic        done,
	output logic        found,
	output logic [63:0] value,
	output logic        created,
	output logic        status,
	output logic        table_empty
);
	cht_pkg::cmd_t cmd;
	cht_pkg::sts_t sts;

	cht_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	cht_dp #(.NUM_BUCKETS(NUM_BUCKETS), .POOL_ENTRIES(POOL_ENTRIES)) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.kind            (kind),
		.key             (key),
		.new_value       (new_value),
		.bucket_count_we (bucket_count_we),
		.bucket_count    (bucket_count),
		.found           (found),
		.value           (value),
		.created         (created),
		.status          (status),
		.table_empty     (table_empty)
	);

endmodule

// ----- design/cht_hash.sv -----
// iterative fmix64 hash and reduction modulo the bucket count
// depends on cht_pkg
module cht_hash #(
	parameter int NW = 9,
	parameter int BW = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [63:0]   key,
	input  logic [NW-1:0] n,
	output logic          done,
	output logic [BW-1:0] bucket
);
	localparam int RW = NW + 1;

	typedef enum logic [4:0] {
		HP_IDLE = 5'b00001,
		HP_MUL1 = 5'b00010,
		HP_MUL2 = 5'b00100,
		HP_MOD  = 5'b01000,
		HP_DONE = 5'b10000
	} hphase_t;

	hphase_t     phase_q;
	logic [3:0]  cnt_q;
	logic [63:0] opnd_q;
	logic [63:0] acc_q;
	logic [RW-1:0] rem_q;
	logic [63:0] cst;
	logic [31:0] ma, mb;
	logic [63:0] prod;
	logic [RW-1:0] rem_nxt;
	logic [RW-1:0] r;

	always_comb begin
		cst = (phase_q == HP_MUL2) ? cht_pkg::FMIX_C2 : cht_pkg::FMIX_C1;
		ma = (cnt_q[1:0] == 2'd2) ? opnd_q[63:32] : opnd_q[31:0];
		mb = (cnt_q[1:0] == 2'd1) ? cst[63:32] : cst[31:0];
		prod = {32'd0, ma} * {32'd0, mb};
	end

	always_comb begin
		r = rem_q;
		for (int j = 0; j < int'(cht_pkg::MOD_BITS_PER_CYCLE); j++) begin
			r = {r[RW-2:0], opnd_q[63-j]};
			if (r >= RW'(n))
				r = r - RW'(n);
		end
		rem_nxt = r;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= HP_IDLE;
			cnt_q <= '0;
		end else begin
			unique case (phase_q)
				HP_IDLE: begin
					cnt_q <= '0;
					if (start)
						phase_q <= HP_MUL1;
				end
				HP_MUL1: begin
					cnt_q <= (cnt_q[1:0] == 2'd3) ? 4'd0 : cnt_q + 4'd1;
					if (cnt_q[1:0] == 2'd3)
						phase_q <= HP_MUL2;
				end
				HP_MUL2: begin
					cnt_q <= (cnt_q[1:0] == 2'd3) ? 4'd0 : cnt_q + 4'd1;
					if (cnt_q[1:0] == 2'd3)
						phase_q <= HP_MOD;
				end
				HP_MOD: begin
					cnt_q <= cnt_q + 4'd1;
					if (cnt_q == 4'hf)
						phase_q <= HP_DONE;
				end
				HP_DONE: phase_q <= HP_IDLE;
				default: phase_q <= HP_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (phase_q == HP_IDLE && start) begin
			opnd_q <= key ^ (key >> cht_pkg::FMIX_SHIFT);
			rem_q <= '0;
		end else if (phase_q == HP_MUL1 || phase_q == HP_MUL2) begin
			case (cnt_q[1:0])
				2'd0: acc_q <= prod;
				2'd1, 2'd2: acc_q[63:32] <= acc_q[63:32] + prod[31:0];
				default: opnd_q <= acc_q ^ (acc_q >> cht_pkg::FMIX_SHIFT);
			endcase
		end else if (phase_q == HP_MOD) begin
			rem_q <= rem_nxt;
			opnd_q <= opnd_q << cht_pkg::MOD_BITS_PER_CYCLE;
		end
	end

	assign done = (phase_q == HP_DONE);
	assign bucket = rem_q[BW-1:0];

endmodule

// ----- design/cht_ctrl.sv -----
// operation sequencer of the chained hash table engine
// depends on cht_pkg
module cht_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  cht_pkg::sts_t     sts,
	output cht_pkg::cmd_t     cmd,
	output logic              busy,
	output logic              done
);
	typedef enum logic [7:0] {
		S_IDLE = 8'b00000001,
		S_HASH = 8'b00000010,
		S_CHK  = 8'b00000100,
		S_WALK = 8'b00001000,
		S_ACT  = 8'b00010000,
		S_POP  = 8'b00100000,
		S_RMH  = 8'b01000000,
		S_RESP = 8'b10000000
	} state_t;

	state_t state_q, state_nxt;

	always_comb begin
		cmd = '0;
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_nxt = S_HASH;
				end
			end
			S_HASH: begin
				if (sts.hash_done) begin
					cmd.rd_head = 1'b1;
					state_nxt = S_CHK;
				end
			end
			S_CHK: begin
				if (!sts.head_valid) begin
					state_nxt = S_ACT;
				end else if (sts.head_hit) begin
					cmd.hit_head = 1'b1;
					state_nxt = S_ACT;
				end else if (sts.head_link_null) begin
					state_nxt = S_ACT;
				end else begin
					cmd.walk_first = 1'b1;
					state_nxt = S_WALK;
				end
			end
			S_WALK: begin
				if (sts.pool_hit) begin
					cmd.hit_pool = 1'b1;
					state_nxt = S_ACT;
				end else if (sts.pool_link_null) begin
					state_nxt = S_ACT;
				end else begin
					cmd.walk_next = 1'b1;
				end
			end
			S_ACT: begin
				state_nxt = S_RESP;
				unique case (sts.kind) inside
					cht_pkg::KIND_LOOKUP: ;
					cht_pkg::KIND_SET, cht_pkg::KIND_GOC: begin
						if (sts.found) begin
							cmd.wr_value = (sts.kind == cht_pkg::KIND_SET);
						end else if (!sts.head_valid) begin
							cmd.ins_head = 1'b1;
						end else if (sts.free_empty) begin
							cmd.full = 1'b1;
						end else begin
							cmd.rd_free = 1'b1;
							state_nxt = S_POP;
						end
					end
					default: begin
						if (sts.found) begin
							if (!sts.at_head) begin
								cmd.rm_chain = 1'b1;
							end else if (sts.head_link_null) begin
								cmd.rm_head_last = 1'b1;
							end else begin
								cmd.rd_next = 1'b1;
								state_nxt = S_RMH;
							end
						end
					end
				endcase
			end
			S_POP: begin
				cmd.ins_pool = 1'b1;
				state_nxt = S_RESP;
			end
			S_RMH: begin
				cmd.rm_head_pull = 1'b1;
				state_nxt = S_RESP;
			end
			S_RESP: state_nxt = S_IDLE;
			default: state_nxt = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_nxt;
	end

	assign busy = (state_q != S_IDLE);
	assign done = (state_q == S_RESP);

endmodule

// ----- design/cht_dp.sv -----
// datapath: bucket and pool memories, free stack, counters, hash unit
// depends on cht_pkg and cht_hash
module cht_dp #(
	parameter int NUM_BUCKETS  = 256,
	parameter int POOL_ENTRIES = 256
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cht_pkg::cmd_t        cmd,
	output cht_pkg::sts_t        sts,
	input  logic [1:0]           kind,
	input  logic [63:0]          key,
	input  logic [63:0]          new_value,
	input  logic                 bucket_count_we,
	input  logic [8:0]           bucket_count,
	output logic                 found,
	output logic [63:0]          value,
	output logic                 created,
	output logic                 status,
	output logic                 table_empty
);
	localparam int NW  = $clog2(NUM_BUCKETS + 1);
	localparam int BW  = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
	localparam int PW  = (POOL_ENTRIES > 1) ? $clog2(POOL_ENTRIES) : 1;
	localparam int LW  = $clog2(POOL_ENTRIES + 1);
	localparam int FCW = $clog2(POOL_ENTRIES + 1);
	localparam int ECW = $clog2(NUM_BUCKETS + POOL_ENTRIES + 1);
	localparam logic [LW-1:0]  LNULL = LW'(POOL_ENTRIES);
	localparam logic [FCW-1:0] FC_FULL = FCW'(POOL_ENTRIES);

	logic [63:0] head_key_mem   [NUM_BUCKETS];
	logic [63:0] head_value_mem [NUM_BUCKETS];
	logic [LW-1:0] head_link_mem [NUM_BUCKETS];
	logic [63:0] pool_key_mem   [POOL_ENTRIES];
	logic [63:0] pool_value_mem [POOL_ENTRIES];
	logic [LW-1:0] pool_link_mem [POOL_ENTRIES];
	logic [PW-1:0] free_mem     [POOL_ENTRIES];
	logic [NUM_BUCKETS-1:0] head_valid_q;

	logic [8:0]  bc_q;
	logic        bc_max_q;
	logic [NW-1:0] n_eff;
	cht_pkg::kind_t kind_q;
	logic [63:0] key_q, nv_q;
	logic [BW-1:0] b_q;
	logic [PW-1:0] cur_q;
	logic [LW-1:0] prev_q;
	logic        found_q, at_head_q, inserted_q, full_q;
	logic [63:0] hk_rd, hv_rd, pk_rd, pv_rd;
	logic [LW-1:0] hl_rd, pl_rd;
	logic [PW-1:0] fs_rd;
	logic        fs_orig_q;
	logic [FCW-1:0] fc_q, lw_q, pop_pos;
	logic [ECW-1:0] ec_q;
	logic        hash_done;
	logic [BW-1:0] hash_bucket;
	logic [PW-1:0] new_idx;
	logic [PW-1:0] pool_raddr;
	logic        pool_rd;
	logic        push;
	logic [PW-1:0] push_idx;
	logic        ec_dec;

	always_comb begin
		if (bc_max_q || 32'(bc_q) > 32'(NUM_BUCKETS))
			n_eff = NW'(NUM_BUCKETS);
		else if (bc_q == 9'd0)
			n_eff = NW'(1);
		else
			n_eff = NW'(bc_q);
	end

	cht_hash #(.NW(NW), .BW(BW)) u_hash (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.load),
		.key    (key),
		.n      (n_eff),
		.done   (hash_done),
		.bucket (hash_bucket)
	);

	assign pop_pos = fc_q - FCW'(1);
	assign new_idx = fs_orig_q ? pop_pos[PW-1:0] : fs_rd;
	assign pool_rd = cmd.walk_first | cmd.walk_next | cmd.rd_next;
	assign pool_raddr = cmd.walk_next ? pl_rd[PW-1:0] : hl_rd[PW-1:0];
	assign push = cmd.rm_head_pull | cmd.rm_chain;
	assign push_idx = cmd.rm_chain ? cur_q : hl_rd[PW-1:0];
	assign ec_dec = cmd.rm_head_last | cmd.rm_head_pull | cmd.rm_chain;

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bc_max_q <= 1'b1;
			head_valid_q <= '0;
			fc_q <= FC_FULL;
			lw_q <= FC_FULL;
			ec_q <= '0;
		end else begin
			if (bucket_count_we)
				bc_max_q <= 1'b0;
			if (cmd.ins_head)
				head_valid_q[b_q] <= 1'b1;
			else if (cmd.rm_head_last)
				head_valid_q[b_q] <= 1'b0;
			if (cmd.ins_pool) begin
				fc_q <= pop_pos;
				if (pop_pos < lw_q)
					lw_q <= pop_pos;
			end else if (push && fc_q < FC_FULL) begin
				fc_q <= fc_q + FCW'(1);
			end
			if (cmd.ins_head || cmd.ins_pool)
				ec_q <= ec_q + ECW'(1);
			else if (ec_dec && ec_q != '0)
				ec_q <= ec_q - ECW'(1);
		end
	end

	// operation registers
	always_ff @(posedge clk) begin
		if (bucket_count_we)
			bc_q <= bucket_count;
		if (cmd.load) begin
			kind_q <= cht_pkg::kind_t'(kind);
			key_q <= key;
			nv_q <= new_value;
			found_q <= 1'b0;
			at_head_q <= 1'b0;
			inserted_q <= 1'b0;
			full_q <= 1'b0;
		end
		if (cmd.rd_head)
			b_q <= hash_bucket;
		if (cmd.hit_head) begin
			found_q <= 1'b1;
			at_head_q <= 1'b1;
		end
		if (cmd.hit_pool)
			found_q <= 1'b1;
		if (cmd.walk_first) begin
			cur_q <= hl_rd[PW-1:0];
			prev_q <= LNULL;
		end
		if (cmd.walk_next) begin
			cur_q <= pl_rd[PW-1:0];
			prev_q <= LW'(cur_q);
		end
		if (cmd.ins_head || cmd.ins_pool)
			inserted_q <= 1'b1;
		if (cmd.full)
			full_q <= 1'b1;
		if (cmd.rd_free)
			fs_orig_q <= (pop_pos < lw_q);
	end

	// bucket head memories
	always_ff @(posedge clk) begin
		if (cmd.rd_head) begin
			hk_rd <= head_key_mem[hash_bucket];
			hv_rd <= head_value_mem[hash_bucket];
			hl_rd <= head_link_mem[hash_bucket];
		end
		if (cmd.ins_head)
			head_key_mem[b_q] <= key_q;
		else if (cmd.rm_head_pull)
			head_key_mem[b_q] <= pk_rd;
		if (cmd.ins_head || (cmd.wr_value && at_head_q))
			head_value_mem[b_q] <= nv_q;
		else if (cmd.rm_head_pull)
			head_value_mem[b_q] <= pv_rd;
		if (cmd.ins_head)
			head_link_mem[b_q] <= LNULL;
		else if (cmd.ins_pool)
			head_link_mem[b_q] <= LW'(new_idx);
		else if (cmd.rm_head_pull || (cmd.rm_chain && prev_q == LNULL))
			head_link_mem[b_q] <= pl_rd;
	end

	// overflow pool memories
	always_ff @(posedge clk) begin
		if (pool_rd) begin
			pk_rd <= pool_key_mem[pool_raddr];
			pv_rd <= pool_value_mem[pool_raddr];
			pl_rd <= pool_link_mem[pool_raddr];
		end
		if (cmd.ins_pool)
			pool_key_mem[new_idx] <= key_q;
		if (cmd.ins_pool)
			pool_value_mem[new_idx] <= nv_q;
		else if (cmd.wr_value && !at_head_q)
			pool_value_mem[cur_q] <= nv_q;
		if (cmd.ins_pool)
			pool_link_mem[new_idx] <= hl_rd;
		else if (cmd.rm_chain && prev_q != LNULL)
			pool_link_mem[prev_q[PW-1:0]] <= pl_rd;
	end

	// free stack, entries below the low-water mark still hold their own index
	always_ff @(posedge clk) begin
		if (cmd.rd_free)
			fs_rd <= free_mem[pop_pos[PW-1:0]];
		if (push && fc_q < FC_FULL)
			free_mem[fc_q[PW-1:0]] <= push_idx;
	end

	always_comb begin
		sts.hash_done = hash_done;
		sts.kind = kind_q;
		sts.head_valid = head_valid_q[b_q];
		sts.head_hit = (hk_rd == key_q);
		sts.head_link_null = (hl_rd == LNULL);
		sts.pool_hit = (pk_rd == key_q);
		sts.pool_link_null = (pl_rd == LNULL);
		sts.found = found_q;
		sts.at_head = at_head_q;
		sts.free_empty = (fc_q == '0);
	end

	always_comb begin
		value = '0;
		if (kind_q == cht_pkg::KIND_LOOKUP || kind_q == cht_pkg::KIND_GOC) begin
			if (found_q)
				value = at_head_q ? hv_rd : pv_rd;
			else if (inserted_q)
				value = nv_q;
		end
	end

	assign found = found_q;
	assign created = inserted_q && (kind_q == cht_pkg::KIND_GOC);
	assign status = full_q;
	assign table_empty = (ec_q == '0);

endmodule

// ----- design/cht_checker.sv -----
// port-level checks of the chained hash table engine, bound to the top level
// depends on assert_macros.svh
`include "assert_macros.svh"

module cht_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        done,
	input logic        found,
	input logic [63:0] value,
	input logic        created,
	input logic        status
);
	`CHT_ASSERT_NXT(a_accept_busy, start && !busy, busy, "accepted item did not raise busy")
	`CHT_ASSERT_IMP(a_done_busy, done, busy, "result strobe while idle")
	`CHT_ASSERT_NXT(a_done_single, done, !done && !busy, "result strobe longer than one cycle")
	`CHT_ASSERT_IMP(a_created_new, done && created, !found && !status, "created on a hit or refusal")
	`CHT_ASSERT_IMP(a_full_clean, done && status, value == 64'd0 && !created, "refusal carries data")
endmodule

bind chained_hash_table_engine_top cht_checker u_cht_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.start   (start),
	.busy    (busy),
	.done    (done),
	.found   (found),
	.value   (value),
	.created (created),
	.status  (status)
);
